[rtl/core/rmn_pkg.sv]
// Shared types and constants for the RGB max normalizer.
package rmn_pkg;

  localparam int unsigned CHAN_W    = 16;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned PIX_W     = CHAN_W * NUM_CHAN;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned DIV_STEPS = CHAN_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SCALE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic load_max;
    logic update_max;
    logic start_div;
    logic step_div;
    logic load_out;
  } cmd_t;

endpackage

[rtl/core/rgb_max_normalizer_top.sv]
// Top level of the RGB max normalizer: controller, datapath and checks.
//
// The host streams a pixel range twice over the slave channel. tuser holds
// the action: 0 measures and restarts the running maximum, 1 measures, 2
// scales the pixel and emits it, 3 is dropped. tdata holds red, green, blue.
// After a measure transfer the block is ready again on the next cycle. A
// scale transfer runs three restoring dividers in parallel for 16 steps,
// one quotient bit per cycle, then loads the output register when it is
// empty or being taken; the input is not ready until then. Each output
// channel is floor(c*65535/max), saturated to 65535, or 0 when the
// maximum is 0. The result waits in the output register on the master
// channel; a new transfer can be taken meanwhile, but a following scale
// result is held in the dividers until the receiver takes the previous one.
// Reset clears the running maximum to 0 and empties the output register.
module rgb_max_normalizer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rmn_pkg::PIX_W-1:0] s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic [rmn_pkg::ACT_W-1:0] s_axis_tuser_i,  // action
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [rmn_pkg::PIX_W-1:0] m_axis_tdata_o   // red_out, green_out, blue_out
);

  rmn_pkg::cmd_t cmd;

  rmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  rmn_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pix_i  (s_axis_tdata_i),
    .pix_o  (m_axis_tdata_o)
  );

  a_scale_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == rmn_pkg::ACT_SCALE))
    |=> !s_axis_tready_o)
    else $error("scale transfer did not start the divider");

  a_measure_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != rmn_pkg::ACT_SCALE))
    |=> s_axis_tready_o)
    else $error("measure transfer stalled the input");

  a_out_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a division");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == rmn_pkg::ACT_SCALE))
    |=> ##16 !s_axis_tready_o)
    else $error("division ended early");

endmodule

[rtl/core/rmn_ctrl.sv]
// Controller state machine: handshakes, division step count, output valid.
module rmn_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [rmn_pkg::ACT_W-1:0] in_action_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rmn_pkg::cmd_t             cmd_o
);

  rmn_pkg::state_e                state_q, state_d;
  logic [rmn_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           last_step;

  assign last_step = (cnt_q == rmn_pkg::CNT_W'(rmn_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      rmn_pkg::ST_IDLE: begin
        if (in_valid_i && (in_action_i == rmn_pkg::ACT_SCALE)) begin
          state_d = rmn_pkg::ST_DIV;
        end
      end
      rmn_pkg::ST_DIV: begin
        if (last_step) begin
          state_d = rmn_pkg::ST_HOLD;
        end
      end
      rmn_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = rmn_pkg::ST_IDLE;
        end
      end
      default: state_d = rmn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      rmn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          case (in_action_i)
            rmn_pkg::ACT_RESTART: cmd_o.load_max   = 1'b1;
            rmn_pkg::ACT_MEASURE: cmd_o.update_max = 1'b1;
            rmn_pkg::ACT_SCALE:   cmd_o.start_div  = 1'b1;
            default:              cmd_o            = '0;
          endcase
        end
      end
      rmn_pkg::ST_DIV: begin
        cmd_o.step_div = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      rmn_pkg::ST_HOLD: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmn_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/rmn_datapath.sv]
// Datapath: running maximum, three bit-serial restoring dividers, output register.
module rmn_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rmn_pkg::cmd_t             cmd_i,
  input  logic [rmn_pkg::PIX_W-1:0] pix_i,
  output logic [rmn_pkg::PIX_W-1:0] pix_o
);

  localparam int unsigned W = rmn_pkg::CHAN_W;
  localparam int unsigned N = rmn_pkg::NUM_CHAN;

  logic [W-1:0] chan   [N];
  logic [W-1:0] pix_max;
  logic [W-1:0] max_q, max_d;

  logic [W-1:0]   rem_q [N];
  logic [W-1:0]   rem_d [N];
  logic [W-1:0]   low_q [N];
  logic [W-1:0]   low_d [N];
  logic [N-1:0]   sat_q, sat_d;
  logic           zero_q, zero_d;
  logic [2*W-1:0] num   [N];
  logic [W:0]     trial [N];
  logic           fits  [N];
  logic [W-1:0]   res   [N];
  logic [rmn_pkg::PIX_W-1:0] out_q, out_d;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      chan[i] = pix_i[i*W +: W];
    end
    pix_max = (chan[0] > chan[1]) ? chan[0] : chan[1];
    pix_max = (pix_max > chan[2]) ? pix_max : chan[2];
  end

  always_comb begin
    max_d = max_q;
    if (cmd_i.load_max) begin
      max_d = pix_max;
    end else if (cmd_i.update_max && (pix_max > max_q)) begin
      max_d = pix_max;
    end
  end

  // c*65535 = (c << 16) - c; quotient bits shift into the low word
  always_comb begin
    zero_d = zero_q;
    sat_d  = sat_q;
    for (int i = 0; i < N; i++) begin
      num[i]   = {chan[i], {W{1'b0}}} - {{W{1'b0}}, chan[i]};
      trial[i] = {rem_q[i], low_q[i][W-1]};
      fits[i]  = (trial[i] >= {1'b0, max_q});
      rem_d[i] = rem_q[i];
      low_d[i] = low_q[i];
      if (cmd_i.start_div) begin
        rem_d[i] = num[i][2*W-1:W];
        low_d[i] = num[i][W-1:0];
        sat_d[i] = (chan[i] >= max_q);
      end else if (cmd_i.step_div) begin
        rem_d[i] = fits[i] ? W'(trial[i] - {1'b0, max_q}) : trial[i][W-1:0];
        low_d[i] = {low_q[i][W-2:0], fits[i]};
      end
      if (zero_q) begin
        res[i] = '0;
      end else if (sat_q[i]) begin
        res[i] = {W{1'b1}};
      end else begin
        res[i] = low_q[i];
      end
    end
    if (cmd_i.start_div) begin
      zero_d = (max_q == '0);
    end
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      for (int i = 0; i < N; i++) begin
        out_d[i*W +: W] = res[i];
      end
    end
  end

  assign pix_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      rem_q[i] <= rem_d[i];
      low_q[i] <= low_d[i];
    end
    sat_q  <= sat_d;
    zero_q <= zero_d;
    out_q  <= out_d;
  end

endmodule

[test/rgb_max_normalizer_top_test.sv]
// Testbench for rgb_max_normalizer_top: streamed measure/scale passes checked against a predictor.
`timescale 1ns / 1ps

module rgb_max_normalizer_top_test;

  localparam logic [rmn_pkg::ACT_W-1:0] ACT_DROP = 2'd3;
  localparam int unsigned TOTAL_ITEMS   = 1900;
  localparam int unsigned HOLD_AFTER    = 700;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [rmn_pkg::CHAN_W-1:0] b;
    logic [rmn_pkg::CHAN_W-1:0] g;
    logic [rmn_pkg::CHAN_W-1:0] r;
  } pixel_t;

  class NormScoreboard;
    logic [rmn_pkg::CHAN_W-1:0] peak;
    logic [rmn_pkg::PIX_W-1:0]  scaled_q[$];
    int unsigned                errors;

    function new();
      peak   = '0;
      errors = 0;
    endfunction

    function logic [rmn_pkg::CHAN_W-1:0] scale_chan(logic [rmn_pkg::CHAN_W-1:0] c);
      logic [31:0] q;
      if (peak == '0) return '0;
      q = (32'(c) * 32'd65535) / 32'(peak);
      if (q > 32'd65535) return '1;
      return q[rmn_pkg::CHAN_W-1:0];
    endfunction

    function void note_pixel(logic [rmn_pkg::ACT_W-1:0] act, pixel_t px);
      logic [rmn_pkg::CHAN_W-1:0] pix_max;
      pix_max = (px.r > px.g) ? px.r : px.g;
      if (px.b > pix_max) pix_max = px.b;
      case (act)
        rmn_pkg::ACT_RESTART: peak = pix_max;
        rmn_pkg::ACT_MEASURE: if (pix_max > peak) peak = pix_max;
        rmn_pkg::ACT_SCALE: begin
          scaled_q.push_back({scale_chan(px.b), scale_chan(px.g), scale_chan(px.r)});
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [rmn_pkg::PIX_W-1:0] got);
      logic [rmn_pkg::PIX_W-1:0] want;
      string chan_name[rmn_pkg::NUM_CHAN];
      chan_name = '{"red", "green", "blue"};
      if (scaled_q.size() == 0) begin
        $display("%0t: unexpected output transfer %h", $time, got);
        errors++;
        return;
      end
      want = scaled_q.pop_front();
      for (int i = 0; i < rmn_pkg::NUM_CHAN; i++) begin
        if (got[i*rmn_pkg::CHAN_W +: rmn_pkg::CHAN_W] !==
            want[i*rmn_pkg::CHAN_W +: rmn_pkg::CHAN_W]) begin
          $display("%0t: %s mismatch, expected %h, actual %h", $time, chan_name[i],
                   want[i*rmn_pkg::CHAN_W +: rmn_pkg::CHAN_W],
                   got[i*rmn_pkg::CHAN_W +: rmn_pkg::CHAN_W]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return scaled_q.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  logic [rmn_pkg::PIX_W-1:0] s_axis_tdata_i;   // red_in, green_in, blue_in
  logic [rmn_pkg::ACT_W-1:0] s_axis_tuser_i;   // action
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  logic [rmn_pkg::PIX_W-1:0] m_axis_tdata_o;   // red_out, green_out, blue_out

  NormScoreboard sb;
  int unsigned   sent_cnt;
  int unsigned   accepted_cnt;
  int unsigned   burst_left;
  int unsigned   cycle_cnt;

  rgb_max_normalizer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_pixel(s_axis_tuser_i, pixel_t'(s_axis_tdata_i));
        accepted_cnt++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_pixel(m_axis_tdata_o);
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic [rmn_pkg::ACT_W-1:0] act, input pixel_t px);
    int unsigned gap;
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = act;
    s_axis_tdata_i  = px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    if (act != ACT_DROP) sent_cnt++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [rmn_pkg::CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return rmn_pkg::CHAN_W'($urandom_range(0, 255));
      3: return rmn_pkg::CHAN_W'(1) << $urandom_range(0, rmn_pkg::CHAN_W - 1);
      default: return rmn_pkg::CHAN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.r = rand_chan();
    px.g = rand_chan();
    px.b = rand_chan();
    return px;
  endfunction

  task automatic send_noise();
    if ($urandom_range(0, 14) == 0) send_pixel(ACT_DROP, rand_pixel());
  endtask

  // one range: measure pass, then scale pass over the same pixels (or, in some ranges, partly random ones)
  task automatic run_range();
    pixel_t      frame[$];
    pixel_t      px;
    int unsigned n;
    int unsigned kind;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      px = (kind == 2) ? pixel_t'('0) : rand_pixel();
      frame.push_back(px);
      send_noise();
      if (i == 0 && kind != 0) send_pixel(rmn_pkg::ACT_RESTART, px);
      else send_pixel(rmn_pkg::ACT_MEASURE, px);
    end
    foreach (frame[i]) begin
      send_noise();
      if (kind == 1 || kind == 2) begin
        send_pixel(rmn_pkg::ACT_SCALE, ($urandom_range(0, 1) == 0) ? rand_pixel() : frame[i]);
      end else begin
        send_pixel(rmn_pkg::ACT_SCALE, frame[i]);
      end
    end
  endtask

  initial begin
    int unsigned rx_cycle;
    int unsigned rx_mode;
    bit          held_off;
    rx_cycle        = 0;
    rx_mode         = 0;
    held_off        = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!held_off && accepted_cnt >= HOLD_AFTER) begin
        held_off        = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: m_axis_tready_i = 1'b1;
          1: m_axis_tready_i = ($urandom_range(0, 3) != 0);
          2: m_axis_tready_i = ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i = ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb              = new();
    sent_cnt        = 0;
    accepted_cnt    = 0;
    burst_left      = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = rmn_pkg::ACT_RESTART;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero maximum after reset
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0000, g: 16'h0001, r: 16'hFFFF});
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h0000, g: 16'h0000, r: 16'h0000});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'hFFFF, g: 16'h0000, r: 16'h0005});
    // full-scale maximum
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h0000, g: 16'h0000, r: 16'hFFFF});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0001, g: 16'h8000, r: 16'hFFFF});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0000, g: 16'h0000, r: 16'h0000});
    // channels above the maximum saturate
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h0001, g: 16'h0001, r: 16'h0001});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'hFFFF, g: 16'h0000, r: 16'h0001});
    // measure raises, never lowers
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h012C, g: 16'h00C8, r: 16'h0064});
    send_pixel(rmn_pkg::ACT_MEASURE, '{b: 16'h0006, g: 16'h0005, r: 16'h0190});
    send_pixel(rmn_pkg::ACT_MEASURE, '{b: 16'h0003, g: 16'h0002, r: 16'h0001});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0001, g: 16'h012C, r: 16'h0190});
    // unused action leaves the maximum alone
    send_pixel(ACT_DROP,             '{b: 16'hFFFF, g: 16'hFFFF, r: 16'hFFFF});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0190, g: 16'h0190, r: 16'h0190});
    // maximum in green, then in blue
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h1234, g: 16'hFF00, r: 16'h00FF});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h1234, g: 16'hFF00, r: 16'h00FF});
    send_pixel(rmn_pkg::ACT_MEASURE, '{b: 16'hFFFE, g: 16'h0000, r: 16'h0000});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'hFFFE, g: 16'hFFFF, r: 16'h7FFF});
    // restart may lower the maximum
    send_pixel(rmn_pkg::ACT_RESTART, '{b: 16'h0002, g: 16'h0003, r: 16'h0001});
    send_pixel(rmn_pkg::ACT_SCALE,   '{b: 16'h0002, g: 16'h0003, r: 16'h0001});

    while (sent_cnt < TOTAL_ITEMS) run_range();
    s_axis_tvalid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
